>>> design/assert_macros.svh
// Shared assertion macros. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/pts_pkg.sv
package pts_pkg;

    localparam int PTS_INDEX_WIDTH = 32;
    localparam int OUT_W           = 32;
    localparam int MAX_RES         = 5;
    localparam int RES_CNT_W       = $clog2(MAX_RES + 1);
    localparam int HELD_DEPTH      = 3;

    localparam logic [OUT_W-1:0] RESTART_MARK = '1;

    typedef enum logic [1:0] {
        FUNC_STRIP = 2'd0,
        FUNC_TRI   = 2'd1,
        FUNC_QUAD  = 2'd2,
        FUNC_FAN   = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] vertex_index;
        logic        list_end;
    } vtx_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] out_index;
        logic             is_restart;
        logic             last_of_run;
    } strip_item_t;

endpackage

>>> design/pts_stream_if.sv
interface pts_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/primitive_to_strip_converter.sv
// Channel | Dir | Payload                              | Transaction
// --------+-----+--------------------------------------+----------------------------
// vtx     | in  | func, vertex_index, list_end         | valid & ready on clk rise
// strip   | out | out_index, is_restart, last_of_run   | valid & ready on clk rise
//
// Each vtx transaction is decoded combinationally into 0..5 strip results,
// loaded into a five-slot result buffer and drained one result per cycle
// while strip.ready is high.
// vtx.ready rises while the last buffered result is being taken, so items
// follow back to back; ready is combinational from strip.ready.
// Reset (rst_n, async, low) empties the buffer and returns to list start.
module primitive_to_strip_converter
    import pts_pkg::*;
#(
    parameter int INDEX_WIDTH = PTS_INDEX_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    pts_stream_if.sink    vtx,
    pts_stream_if.source  strip
);

    localparam int POS_W  = 3;
    localparam int HELD_W = $clog2(HELD_DEPTH);

    // list state
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [INDEX_WIDTH-1:0] center_reg, center_next;
    logic [INDEX_WIDTH-1:0] held_reg [HELD_DEPTH];
    logic [INDEX_WIDTH-1:0] held_next [HELD_DEPTH];

    // result buffer
    logic [OUT_W-1:0]       buf_idx_reg [MAX_RES];
    logic [MAX_RES-1:0]     buf_rst_reg;
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RES_CNT_W-1:0]   ptr_reg, ptr_next;

    // decode of the incoming item
    logic [OUT_W-1:0]       res_idx [MAX_RES];
    logic [MAX_RES-1:0]     res_rst;
    logic [RES_CNT_W-1:0]   res_n;
    logic [POS_W-1:0]       pos_eff;
    logic [INDEX_WIDTH-1:0] cur;
    logic [OUT_W-1:0]       cur_x, center_x;
    logic [OUT_W-1:0]       held_x [HELD_DEPTH];
    logic                   list_end;

    logic at_last, take, accept;

    assign cur      = vtx.payload.vertex_index[INDEX_WIDTH-1:0];
    assign list_end = vtx.payload.list_end;
    assign cur_x    = OUT_W'(cur);
    assign center_x = OUT_W'(center_reg);

    always_comb
    begin
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            held_x[i] = OUT_W'(held_reg[i]);
        end
    end

    // Handshake: take the next item as the buffer empties.
    assign at_last     = (ptr_reg == cnt_reg - RES_CNT_W'(1));
    assign take        = strip.valid && strip.ready;
    assign vtx.ready   = (cnt_reg == '0) || (take && at_last);
    assign accept      = vtx.valid && vtx.ready;

    // Item decode. Unused slots default to the restart marker, so a
    // trailing restart only needs the count to cover it.
    always_comb
    begin
        res_idx     = '{default: RESTART_MARK};
        res_rst     = '1;
        res_n       = '0;
        held_next   = held_reg;
        center_next = center_reg;
        pos_next    = pos_reg;
        pos_eff     = pos_reg;

        case (vtx.payload.func)
            FUNC_STRIP:
            begin
                res_idx[0] = cur_x;
                res_rst[0] = 1'b0;
                res_n      = list_end ? RES_CNT_W'(2) : RES_CNT_W'(1);
            end
            FUNC_TRI:
            begin
                pos_eff = (pos_reg > POS_W'(2)) ? '0 : pos_reg;
                if (pos_eff < POS_W'(2))
                begin
                    held_next[pos_eff[HELD_W-1:0]] = cur;
                    pos_next = pos_eff + POS_W'(1);
                end
                else
                begin
                    res_idx[0] = held_x[0];
                    res_idx[1] = held_x[1];
                    res_idx[2] = cur_x;
                    res_rst[2:0] = '0;
                    res_n    = RES_CNT_W'(4);
                    pos_next = '0;
                end
            end
            FUNC_QUAD:
            begin
                pos_eff = (pos_reg > POS_W'(3)) ? '0 : pos_reg;
                if (pos_eff < POS_W'(3))
                begin
                    held_next[pos_eff[HELD_W-1:0]] = cur;
                    pos_next = pos_eff + POS_W'(1);
                    // list closing on three indices: plain triangle
                    if (pos_eff == POS_W'(2) && list_end)
                    begin
                        res_idx[0] = held_x[0];
                        res_idx[1] = held_x[1];
                        res_idx[2] = cur_x;
                        res_rst[2:0] = '0;
                        res_n = RES_CNT_W'(4);
                    end
                end
                else
                begin
                    // a,b,c,d -> b,c,a,d
                    res_idx[0] = held_x[1];
                    res_idx[1] = held_x[2];
                    res_idx[2] = held_x[0];
                    res_idx[3] = cur_x;
                    res_rst[3:0] = '0;
                    res_n    = RES_CNT_W'(5);
                    pos_next = '0;
                end
            end
            FUNC_FAN:
            begin
                pos_eff = (pos_reg > POS_W'(4)) ? '0 : pos_reg;
                case (pos_eff)
                    POS_W'(0):
                    begin
                        center_next = cur;
                        pos_next    = POS_W'(1);
                    end
                    POS_W'(1):
                    begin
                        held_next[0] = cur;
                        pos_next     = POS_W'(2);
                    end
                    POS_W'(2):
                    begin
                        res_idx[0] = held_x[0];
                        res_idx[1] = cur_x;
                        res_idx[2] = center_x;
                        res_rst[2:0] = '0;
                        res_n    = list_end ? RES_CNT_W'(4) : RES_CNT_W'(3);
                        pos_next = POS_W'(3);
                    end
                    POS_W'(3):
                    begin
                        res_idx[0] = cur_x;
                        res_rst[0] = 1'b0;
                        res_n    = list_end ? RES_CNT_W'(2) : RES_CNT_W'(1);
                        pos_next = POS_W'(4);
                    end
                    default:
                    begin
                        // third triangle closes the group; its last index
                        // opens the next one
                        res_idx[0]   = cur_x;
                        res_rst[0]   = 1'b0;
                        res_n        = RES_CNT_W'(2);
                        held_next[0] = cur;
                        pos_next     = POS_W'(2);
                    end
                endcase
            end
            default:
            begin
                res_n = '0;
            end
        endcase

        if (list_end)
        begin
            pos_next = '0;
        end
    end

    // Buffer pointer and count.
    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (accept)
        begin
            cnt_next = res_n;
            ptr_next = '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                cnt_next = '0;
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            center_reg <= '0;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            if (accept)
            begin
                pos_reg    <= pos_next;
                center_reg <= center_next;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg    <= held_next;
            buf_idx_reg <= res_idx;
            buf_rst_reg <= res_rst;
        end
    end

    assign strip.valid               = (cnt_reg != '0);
    assign strip.payload.out_index   = buf_idx_reg[ptr_reg];
    assign strip.payload.is_restart  = buf_rst_reg[ptr_reg];
    assign strip.payload.last_of_run = at_last;

endmodule

>>> design/pts_checker.sv
`include "assert_macros.svh"

module pts_checker
    import pts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        vtx_valid,
    input logic        vtx_ready,
    input logic        strip_valid,
    input logic        strip_ready,
    input strip_item_t strip_payload
);

    logic vtx_take;
    logic strip_take;
    logic strip_stall;
    logic strip_last;
    logic restart_shown;

    assign vtx_take      = vtx_valid && vtx_ready;
    assign strip_take    = strip_valid && strip_ready;
    assign strip_stall   = strip_valid && !strip_ready;
    assign strip_last    = strip_take && strip_payload.last_of_run;
    assign restart_shown = strip_valid && strip_payload.is_restart;

    // a stalled result holds
    `PTS_ASSERT_NEXT(a_strip_hold, strip_stall, strip_valid && $stable(strip_payload))

    // restart flag and marker value agree
    `PTS_ASSERT_NOW(a_restart_mark, restart_shown, strip_payload.out_index == RESTART_MARK)

    // new input only while the final pending result leaves
    `PTS_ASSERT_NOW(a_ready_gap, vtx_take && strip_valid, strip_last)

    // a run continues until its last result
    `PTS_ASSERT_NEXT(a_run_cont, strip_take && !strip_last, strip_valid)

endmodule

bind primitive_to_strip_converter pts_checker u_pts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .vtx_valid     (vtx.valid),
    .vtx_ready     (vtx.ready),
    .strip_valid   (strip.valid),
    .strip_ready   (strip.ready),
    .strip_payload (strip.payload)
);

>>> tb/tb_primitive_to_strip_converter.sv
module tb_primitive_to_strip_converter;
    import pts_pkg::*;

    // Index width under test; the block is built with its default.
    localparam int          IDX_W    = PTS_INDEX_WIDTH;
    localparam logic [31:0] IDX_MASK = 32'hFFFF_FFFF >> (32 - IDX_W);
    // A result-free transaction owes no result but still needs a handshake, so
    // wait_drained settles after the last result.
    localparam int          SETTLE_CYCLES = 4;
    localparam int          RANDOM_ITEMS  = 290;

    logic clk;
    logic rst_n;

    pts_stream_if #(.T(vtx_item_t))   vtx_ch ();
    pts_stream_if #(.T(strip_item_t)) strip_ch ();

    primitive_to_strip_converter #(
        .INDEX_WIDTH (IDX_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vtx_ch),
        .strip (strip_ch)
    );

    // Clock: period 4.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Idle percentages for the current phase.
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;

    // Counters for the summary and the verdict.
    int unsigned vertices_sent  = 0;
    int unsigned lists_sent     = 0;
    int unsigned strips_checked = 0;
    int unsigned error_count    = 0;

    // Converter state as predicted.
    logic [31:0] fan_center   = '0;
    logic [31:0] held_idx [3];
    logic [2:0]  list_pos     = '0;

    // Strip results still owed by the block, oldest first.
    strip_item_t expected_strips [$];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Append one strip result to the owed results; returns the new count.
    function automatic int owe_strip(int n, logic [31:0] v, logic restart);
        strip_item_t s;
        s.out_index   = v;
        s.is_restart  = restart;
        s.last_of_run = 1'b0;
        expected_strips.insert(expected_strips.size(), s);
        return n + 1;
    endfunction

    function automatic int owe_restart(int n);
        return owe_strip(n, RESTART_MARK, 1'b1);
    endfunction

    // Work out the strip results of one accepted vertex transaction.
    function automatic void predict_strips(vtx_item_t it);
        logic [31:0] cur;
        logic [2:0]  pos;
        logic [2:0]  nxt;
        int          n;
        strip_item_t tail;
        cur = it.vertex_index & IDX_MASK;
        pos = list_pos;
        nxt = pos;
        n   = 0;
        case (it.func)
            FUNC_STRIP:
            begin
                // passthrough keeps the list position untouched unless it ends the list
                n = owe_strip(n, cur, 1'b0);
                if (it.list_end)
                    n = owe_restart(n);
            end
            FUNC_TRI:
            begin
                if (pos > 3'd2)
                    pos = 3'd0;
                if (pos < 3'd2)
                begin
                    held_idx[pos] = cur;
                    nxt = pos + 3'd1;
                end
                else
                begin
                    n = owe_strip(n, held_idx[0], 1'b0);
                    n = owe_strip(n, held_idx[1], 1'b0);
                    n = owe_strip(n, cur, 1'b0);
                    n = owe_restart(n);
                    nxt = 3'd0;
                end
            end
            FUNC_QUAD:
            begin
                if (pos > 3'd3)
                    pos = 3'd0;
                if (pos < 3'd3)
                begin
                    held_idx[pos] = cur;
                    nxt = pos + 3'd1;
                    // trailing group of three closes as a triangle
                    if (pos == 3'd2 && it.list_end)
                    begin
                        n = owe_strip(n, held_idx[0], 1'b0);
                        n = owe_strip(n, held_idx[1], 1'b0);
                        n = owe_strip(n, cur, 1'b0);
                        n = owe_restart(n);
                    end
                end
                else
                begin
                    // a,b,c,d -> b,c,a,d
                    n = owe_strip(n, held_idx[1], 1'b0);
                    n = owe_strip(n, held_idx[2], 1'b0);
                    n = owe_strip(n, held_idx[0], 1'b0);
                    n = owe_strip(n, cur, 1'b0);
                    n = owe_restart(n);
                    nxt = 3'd0;
                end
            end
            default:
            begin
                if (pos > 3'd4)
                    pos = 3'd0;
                case (pos)
                    3'd0:
                    begin
                        fan_center = cur;
                        nxt = 3'd1;
                    end
                    3'd1:
                    begin
                        held_idx[0] = cur;
                        nxt = 3'd2;
                    end
                    3'd2:
                    begin
                        n = owe_strip(n, held_idx[0], 1'b0);
                        n = owe_strip(n, cur, 1'b0);
                        n = owe_strip(n, fan_center, 1'b0);
                        if (it.list_end)
                            n = owe_restart(n);
                        nxt = 3'd3;
                    end
                    3'd3:
                    begin
                        n = owe_strip(n, cur, 1'b0);
                        if (it.list_end)
                            n = owe_restart(n);
                        nxt = 3'd4;
                    end
                    default:
                    begin
                        // group of three done; current starts the next one
                        n = owe_strip(n, cur, 1'b0);
                        n = owe_restart(n);
                        held_idx[0] = cur;
                        nxt = 3'd2;
                    end
                endcase
            end
        endcase
        if (it.list_end)
            nxt = 3'd0;
        list_pos = nxt;
        if (n > 0)
        begin
            tail = expected_strips[$];
            tail.last_of_run = 1'b1;
            expected_strips[expected_strips.size() - 1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one vertex transaction. Entered and left just after a falling
    // edge; valid is left high so that back-to-back items need no dip.
    task automatic send_vertex(func_t f, logic [31:0] idx, logic last);
        vtx_item_t it;
        it.func         = f;
        it.vertex_index = idx;
        it.list_end     = last;
        while ($urandom_range(99) < src_idle_pct)
        begin
            vtx_ch.valid = 1'b0;
            @(negedge clk);
        end
        vtx_ch.valid   = 1'b1;
        vtx_ch.payload = it;
        @(posedge clk);
        while (!vtx_ch.ready)
            @(posedge clk);
        predict_strips(it);
        vertices_sent++;
        if (last)
            lists_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed result is back.
    task automatic wait_drained();
        vtx_ch.valid = 1'b0;
        while (expected_strips.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Index picker biased towards the corners of the field.
    function automatic logic [31:0] pick_index();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'hFFFF_FFFE;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: ready changes at the falling edge only.
    always @(negedge clk)
        strip_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        strip_item_t want;
        strip_item_t got;
        if (rst_n && strip_ch.valid && strip_ch.ready)
        begin
            got = strip_ch.payload;
            if (expected_strips.size() == 0)
            begin
                $error("strip result %h with none owed", got);
                error_count++;
            end
            else
            begin
                want = expected_strips.pop_front();
                strips_checked++;
                if (got.out_index !== want.out_index)
                begin
                    $error("out_index: expected %h, got %h", want.out_index, got.out_index);
                    error_count++;
                end
                if (got.is_restart !== want.is_restart)
                begin
                    $error("is_restart: expected %b, got %b", want.is_restart, got.is_restart);
                    error_count++;
                end
                if (got.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, got.last_of_run);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One whole triangle, then a list ending on a partial triangle (dropped).
    task automatic test_triangles();
        send_vertex(FUNC_TRI, 32'h0000_0000, 1'b0);
        send_vertex(FUNC_TRI, 32'hFFFF_FFFF, 1'b0);
        send_vertex(FUNC_TRI, 32'h8000_0000, 1'b0);
        send_vertex(FUNC_TRI, 32'h7FFF_FFFF, 1'b0);
        send_vertex(FUNC_TRI, 32'h5555_AAAA, 1'b1);
        wait_drained();
    endtask

    // Whole quad, then a trailing group of three, then a lone dropped index.
    task automatic test_quads();
        send_vertex(FUNC_QUAD, 32'h0000_000A, 1'b0);
        send_vertex(FUNC_QUAD, 32'h0000_000B, 1'b0);
        send_vertex(FUNC_QUAD, 32'hAAAA_5555, 1'b0);
        send_vertex(FUNC_QUAD, 32'hFFFF_FFFE, 1'b0);
        send_vertex(FUNC_QUAD, 32'h0000_0001, 1'b0);
        send_vertex(FUNC_QUAD, 32'h0000_0002, 1'b0);
        send_vertex(FUNC_QUAD, 32'h0000_0003, 1'b1);
        send_vertex(FUNC_QUAD, 32'h1234_5678, 1'b1);
        wait_drained();
    endtask

    // Fan of one (dropped), fan of five (full group then restart), and a
    // fan left mid-group that is taken over by a triangle: the triangle
    // sees a position past its own cycle and starts afresh.
    task automatic test_fans();
        send_vertex(FUNC_FAN, 32'h0000_0100, 1'b1);
        send_vertex(FUNC_FAN, 32'h0000_0C00, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0A00, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0B00, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0D00, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0E00, 1'b1);
        send_vertex(FUNC_FAN, 32'h0000_0001, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0002, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0003, 1'b0);
        send_vertex(FUNC_FAN, 32'h0000_0004, 1'b0);
        send_vertex(FUNC_TRI, 32'h0000_0005, 1'b1);
        wait_drained();
    endtask

    // Passthrough copies, including one dropped into the middle of a
    // triangle list, which must not disturb the triangle's position.
    task automatic test_passthrough();
        send_vertex(FUNC_STRIP, 32'hFFFF_FFFF, 1'b0);
        send_vertex(FUNC_STRIP, 32'h0000_0000, 1'b1);
        send_vertex(FUNC_TRI,   32'h0000_0010, 1'b0);
        send_vertex(FUNC_STRIP, 32'h0000_0011, 1'b0);
        send_vertex(FUNC_TRI,   32'h0000_0012, 1'b0);
        send_vertex(FUNC_TRI,   32'h0000_0013, 1'b1);
        wait_drained();
    endtask

    // One random list. Mostly well-formed lists of a single type; some
    // noise lists mix types and carry stray list ends. All held entries
    // have been written by the directed tests, so no mix reads garbage.
    task automatic send_random_list(ref int unsigned budget);
        func_t       f;
        int unsigned len;
        bit          noisy;
        f     = func_t'($urandom_range(3));
        noisy = ($urandom_range(99) < 15);
        case (f)
            FUNC_STRIP: len = $urandom_range(1, 5);
            FUNC_TRI:   len = ($urandom_range(3) == 0) ? $urandom_range(1, 8)
                                                       : 3 * $urandom_range(1, 3);
            FUNC_QUAD:  len = ($urandom_range(3) == 0) ? $urandom_range(1, 9)
                                                       : 4 * $urandom_range(1, 2) +
                                                         3 * $urandom_range(0, 1);
            default:    len = $urandom_range(1, 10);
        endcase
        for (int unsigned k = 0; k < len && budget > 0; k++)
        begin
            if (noisy)
                send_vertex(func_t'($urandom_range(3)), pick_index(),
                            ($urandom_range(9) == 0) || (k == len - 1));
            else
                send_vertex(f, pick_index(), (k == len - 1) || (budget == 1));
            budget--;
        end
    endtask

    // Random lists over four idle phases, draining between phases.
    task automatic test_random_lists();
        int unsigned budget;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 48; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 48; end
                default: begin src_idle_pct = 8;  snk_stall_pct = 8;  end
            endcase
            budget = RANDOM_ITEMS / 4;
            while (budget > 0)
                send_random_list(budget);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        vtx_ch.valid     = 1'b0;
        vtx_ch.payload   = '0;
        strip_ch.ready   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_triangles();
        test_quads();
        test_fans();
        test_passthrough();
        test_random_lists();

        $display("covered %0d vertex transactions in %0d lists, %0d strip results checked",
                 vertices_sent, lists_sent, strips_checked);
        $display("idle phases: none, sender 48%%, receiver 48%%, both 8%%");
        if (error_count == 0)
            $display("tb_primitive_to_strip_converter: done, clean");
        else
            $display("tb_primitive_to_strip_converter: done, errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb_primitive_to_strip_converter: done, errors");
        $finish;
    end

endmodule
